// File: hw/rtl/framed_heartbeat_watchdog_core_defines.svh
// Assertion macros for the framed heartbeat watchdog.
`ifndef FRAMED_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH
`define FRAMED_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH

// same-cycle implication
`define FHW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FHW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fhw_pkg.sv
// Shared types and constants of the framed heartbeat watchdog.
package fhw_pkg;

    localparam int FHW_CMD_BYTES   = 32;
    localparam int FHW_LEN_MAX_W   = 6;
    localparam logic [15:0] FHW_TIMEOUT_RST = 16'd60;
    localparam logic [16:0] FHW_IDLE_MAX    = 17'h1FFFF;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_CLOSED = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [7:0] OP_HEARTBEAT = 8'd2;
    localparam logic [7:0] OP_SHUTDOWN  = 8'd3;
    localparam logic [7:0] OP_SET       = 8'd4;
    localparam logic [7:0] OP_CLEAR     = 8'd5;
    localparam logic [7:0] OP_GET       = 8'd6;
    localparam logic [7:0] OP_GET_REPLY = 8'd7;
    localparam logic [7:0] OP_CRASHING  = 8'd8;

    localparam logic [2:0] REASON_TIMEOUT  = 3'd0;
    localparam logic [2:0] REASON_CLOSED   = 3'd1;
    localparam logic [2:0] REASON_ERROR    = 3'd2;
    localparam logic [2:0] REASON_SHUTDOWN = 3'd3;
    localparam logic [2:0] REASON_CRASHING = 3'd4;

    localparam logic OUT_TX     = 1'b0;
    localparam logic OUT_REPORT = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_OP,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ACT_ACK,
        ACT_GET,
        ACT_TERM
    } act_op_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    typedef struct packed {
        act_op_t                  op;
        logic [2:0]               reason;
        logic                     present;
        logic [FHW_LEN_MAX_W-1:0] len;
        logic                     bank;
    } act_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic [2:0] reason;
        logic       present;
        logic       last;
    } res_t;

endpackage

// File: hw/rtl/fhw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fhw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/fhw_act_queue.sv
// Two-entry action queue between the frame parser and the reply sequencer.
module fhw_act_queue
    import fhw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  act_t wr_act,
    output logic q_full,
    input  logic rd_en,
    output act_t rd_act,
    output logic q_empty
);

    act_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_act  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (rd_en)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/fhw_front.sv
// Front end: item intake, frame parser, idle timer and action classification.
module fhw_front
    import fhw_pkg::*;
#(
    parameter int CMD_BYTES = FHW_CMD_BYTES,
    localparam int BODY_DEPTH = CMD_BYTES - 1,
    localparam int LEN_W = $clog2(CMD_BYTES),
    localparam int ADDR_W = $clog2(2 * BODY_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        item_kind,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_valid,
    input  logic [15:0]       cfg_data,
    output logic              act_push,
    output act_t              act_d,
    input  logic              q_full,
    input  logic              get_done,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata
);

    phase_t      phase_reg, phase_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  fop_reg, fop_next;
    logic [LEN_W-1:0] cmd_len_reg, cmd_len_next;
    logic [LEN_W-1:0] zpos_reg, zpos_next;
    logic        bank_reg, bank_next;
    logic [16:0] idle_reg, idle_next;
    logic        halted_reg, halted_next;
    logic        get_busy_reg, get_busy_next;
    logic [15:0] timeout_reg;

    logic             accept;
    logic             done;
    logic [7:0]       op_sel;
    logic [15:0]      body_idx;
    logic [LEN_W-1:0] body_len;
    logic [LEN_W-1:0] set_len;
    logic [16:0]      idle_inc;

    assign full     = q_full || get_busy_reg;
    assign accept   = push && !full;
    assign body_idx = seen_reg - 16'd1;
    assign body_len = LEN_W'(flen_reg - 16'd1);
    assign set_len  = (zpos_next < body_len) ? zpos_next : body_len;
    assign idle_inc = (idle_reg == FHW_IDLE_MAX) ? idle_reg : idle_reg + 17'd1;
    assign ram_wdata = rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        flen_next     = flen_reg;
        seen_next     = seen_reg;
        fop_next      = fop_reg;
        cmd_len_next  = cmd_len_reg;
        zpos_next     = zpos_reg;
        bank_next     = bank_reg;
        idle_next     = idle_reg;
        halted_next   = halted_reg;
        get_busy_next = get_busy_reg && !get_done;
        act_push      = 1'b0;
        act_d         = '0;
        ram_we        = 1'b0;
        ram_waddr     = ADDR_W'(body_idx[LEN_W-1:0])
                      + (bank_reg ? ADDR_W'(0) : ADDR_W'(BODY_DEPTH));
        done          = 1'b0;
        op_sel        = fop_reg;

        if (accept && !halted_reg)
        begin
            case (item_kind)
                KIND_BYTE:
                begin
                    unique case (phase_reg)
                        PH_LEN_HI:
                        begin
                            flen_next  = {rx_byte, 8'd0};
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            flen_next  = {flen_reg[15:8], rx_byte};
                            seen_next  = 16'd0;
                            phase_next = (flen_next == 16'd0) ? PH_LEN_HI : PH_OP;
                        end
                        PH_OP:
                        begin
                            fop_next  = rx_byte;
                            op_sel    = rx_byte;
                            seen_next = 16'd1;
                            zpos_next = LEN_W'(BODY_DEPTH);
                            if (flen_reg <= 16'd1)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            if (body_idx < 16'(BODY_DEPTH))
                            begin
                                ram_we = 1'b1;
                                if (rx_byte == 8'd0 && zpos_reg == LEN_W'(BODY_DEPTH))
                                begin
                                    zpos_next = body_idx[LEN_W-1:0];
                                end
                            end
                            seen_next = seen_reg + 16'd1;
                            done      = (seen_next >= flen_reg);
                        end
                        default:
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    endcase

                    if (done)
                    begin
                        phase_next = PH_LEN_HI;
                        if (flen_reg <= 16'(CMD_BYTES))
                        begin
                            case (op_sel)
                                OP_HEARTBEAT:
                                begin
                                    idle_next = 17'd0;
                                end
                                OP_SHUTDOWN:
                                begin
                                    act_push      = 1'b1;
                                    act_d.op      = ACT_TERM;
                                    act_d.reason  = REASON_SHUTDOWN;
                                    halted_next   = 1'b1;
                                end
                                OP_SET:
                                begin
                                    cmd_len_next = set_len;
                                    bank_next    = !bank_reg;
                                    act_push     = 1'b1;
                                    act_d.op     = ACT_ACK;
                                end
                                OP_CLEAR:
                                begin
                                    cmd_len_next = '0;
                                    act_push     = 1'b1;
                                    act_d.op     = ACT_ACK;
                                end
                                OP_GET:
                                begin
                                    act_push      = 1'b1;
                                    act_d.op      = ACT_GET;
                                    act_d.len     = FHW_LEN_MAX_W'(cmd_len_reg);
                                    act_d.bank    = bank_reg;
                                    get_busy_next = 1'b1;
                                end
                                OP_CRASHING:
                                begin
                                    act_push      = 1'b1;
                                    act_d.op      = ACT_TERM;
                                    act_d.reason  = REASON_CRASHING;
                                    act_d.present = (cmd_len_reg != '0);
                                    halted_next   = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                KIND_TICK:
                begin
                    idle_next = idle_inc;
                    if (idle_inc > {1'b0, timeout_reg})
                    begin
                        act_push      = 1'b1;
                        act_d.op      = ACT_TERM;
                        act_d.reason  = REASON_TIMEOUT;
                        act_d.present = (cmd_len_reg != '0);
                        halted_next   = 1'b1;
                    end
                end
                default:
                begin
                    act_push      = 1'b1;
                    act_d.op      = ACT_TERM;
                    act_d.reason  = (item_kind == KIND_CLOSED) ? REASON_CLOSED : REASON_ERROR;
                    act_d.present = (cmd_len_reg != '0);
                    halted_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEN_HI;
            flen_reg     <= 16'd0;
            seen_reg     <= 16'd0;
            fop_reg      <= 8'd0;
            cmd_len_reg  <= '0;
            zpos_reg     <= LEN_W'(BODY_DEPTH);
            bank_reg     <= 1'b0;
            idle_reg     <= 17'd0;
            halted_reg   <= 1'b0;
            get_busy_reg <= 1'b0;
            timeout_reg  <= FHW_TIMEOUT_RST;
        end
        else
        begin
            phase_reg    <= phase_next;
            flen_reg     <= flen_next;
            seen_reg     <= seen_next;
            fop_reg      <= fop_next;
            cmd_len_reg  <= cmd_len_next;
            zpos_reg     <= zpos_next;
            bank_reg     <= bank_next;
            idle_reg     <= idle_next;
            halted_reg   <= halted_next;
            get_busy_reg <= get_busy_next;
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hw/rtl/fhw_back.sv
// Back end: reply sequencer, command readout and result queue.
module fhw_back
    import fhw_pkg::*;
#(
    parameter int CMD_BYTES = FHW_CMD_BYTES,
    localparam int BODY_DEPTH = CMD_BYTES - 1,
    localparam int LEN_W = $clog2(CMD_BYTES),
    localparam int ADDR_W = $clog2(2 * BODY_DEPTH),
    localparam int STEP_W = $clog2(CMD_BYTES + 2)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  act_t              q_act,
    output logic              q_pop,
    output logic              get_done,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [7:0]        ram_rdata,
    output logic              empty,
    input  logic              pop,
    output res_t              res
);

    back_state_t state_reg, state_next;
    act_t        cur_reg, cur_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_ram_reg, s1_ram_next;
    res_t        s1_res_reg, s1_res_next;

    res_t        oq_reg [4];
    logic [1:0]  oq_wr_reg, oq_rd_reg;
    logic [2:0]  oq_cnt_reg, oq_cnt_next;

    logic              credit;
    logic              oq_pop;
    logic [STEP_W-1:0] last_step;
    logic [LEN_W-1:0]  rd_idx;
    res_t              oq_in;

    assign credit = ({1'b0, oq_cnt_reg} + {3'd0, s1_valid_reg}) < 4'd4;
    assign oq_pop = pop && !empty;
    assign empty  = (oq_cnt_reg == 3'd0);
    assign res    = oq_reg[oq_rd_reg];
    assign rd_idx = LEN_W'(step_reg - STEP_W'(3));
    assign ram_raddr = ADDR_W'(rd_idx) + (cur_reg.bank ? ADDR_W'(BODY_DEPTH) : ADDR_W'(0));

    always_comb
    begin
        oq_in = s1_res_reg;
        if (s1_ram_reg)
        begin
            oq_in.tx = ram_rdata;
        end
    end

    always_comb
    begin
        unique case (cur_reg.op)
            ACT_ACK:  last_step = STEP_W'(2);
            ACT_GET:  last_step = STEP_W'(cur_reg.len) + STEP_W'(2);
            ACT_TERM: last_step = '0;
            default:  last_step = '0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        s1_valid_next = 1'b0;
        s1_ram_next   = 1'b0;
        s1_res_next   = '0;
        q_pop         = 1'b0;
        get_done      = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_act;
                    step_next  = '0;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (credit)
                begin
                    s1_valid_next    = 1'b1;
                    s1_res_next.last = (step_reg == last_step);
                    unique case (cur_reg.op)
                        ACT_ACK:
                        begin
                            s1_res_next.tx = (step_reg == '0) ? 8'h00 : 8'h01;
                        end
                        ACT_GET:
                        begin
                            if (step_reg == STEP_W'(0))
                            begin
                                s1_res_next.tx = 8'h00;
                            end
                            else if (step_reg == STEP_W'(1))
                            begin
                                s1_res_next.tx = 8'(cur_reg.len) + 8'd1;
                            end
                            else if (step_reg == STEP_W'(2))
                            begin
                                s1_res_next.tx = OP_GET_REPLY;
                            end
                            else
                            begin
                                s1_ram_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            s1_res_next.kind    = OUT_REPORT;
                            s1_res_next.reason  = cur_reg.reason;
                            s1_res_next.present = cur_reg.present;
                        end
                    endcase
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg == last_step)
                    begin
                        state_next = B_IDLE;
                        get_done   = (cur_reg.op == ACT_GET);
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (s1_valid_reg)
        begin
            oq_cnt_next = oq_cnt_next + 3'd1;
        end
        if (oq_pop)
        begin
            oq_cnt_next = oq_cnt_next - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        s1_res_reg <= s1_res_next;
        if (s1_valid_reg)
        begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            step_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_ram_reg   <= 1'b0;
            oq_wr_reg    <= 2'd0;
            oq_rd_reg    <= 2'd0;
            oq_cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            s1_valid_reg <= s1_valid_next;
            s1_ram_reg   <= s1_ram_next;
            oq_cnt_reg   <= oq_cnt_next;
            if (s1_valid_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 2'd1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/framed_heartbeat_watchdog_core.sv
// An accepted item's result passes through the action queue, the reply sequencer and the result queue.
// Throughput: 1 item per cycle while the action queue is not full and no command readout is
// pending; a get-command frame holds input until the readout sequencer finishes its reply.
// Results stream at 1 per cycle from a 4-entry result queue while pop is held and results wait.
// Reset (rst_n low, asynchronous) clears control state and sets the timeout to 60.
module framed_heartbeat_watchdog_core
    import fhw_pkg::*;
#(
    parameter int CMD_BYTES = FHW_CMD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  item_kind,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic        out_kind,
    output logic [7:0]  tx_byte,
    output logic [2:0]  end_reason,
    output logic        command_present,
    output logic        last_of_run
);

    localparam int BODY_DEPTH = CMD_BYTES - 1;
    localparam int ADDR_W = $clog2(2 * BODY_DEPTH);

    logic              act_push, q_full, q_empty, q_pop, get_done;
    act_t              act_d, q_act;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    res_t              res;

    assign cfg_ready       = 1'b1;
    assign out_kind        = res.kind;
    assign tx_byte         = res.tx;
    assign end_reason      = res.reason;
    assign command_present = res.present;
    assign last_of_run     = res.last;

    fhw_front #(.CMD_BYTES(CMD_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item_kind (item_kind),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .act_push  (act_push),
        .act_d     (act_d),
        .q_full    (q_full),
        .get_done  (get_done),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    fhw_act_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_push),
        .wr_act  (act_d),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_act  (q_act),
        .q_empty (q_empty)
    );

    fhw_ram #(.WIDTH(8), .DEPTH(2 * BODY_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fhw_back #(.CMD_BYTES(CMD_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_act     (q_act),
        .q_pop     (q_pop),
        .get_done  (get_done),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

endmodule

// File: hw/rtl/fhw_checker.sv
// Port-level checker for the framed heartbeat watchdog, bound to the top level.
`include "framed_heartbeat_watchdog_core_defines.svh"
module fhw_checker
    import fhw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       out_kind,
    input logic [7:0] tx_byte,
    input logic [2:0] end_reason,
    input logic       command_present,
    input logic       last_of_run
);

    `FHW_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(tx_byte), "result changed while stalled")
    `FHW_ASSERT_NOW(a_report_last, !empty && out_kind, last_of_run, "report not last of run")
    `FHW_ASSERT_NOW(a_shutdown_cmd, !empty && out_kind && end_reason == REASON_SHUTDOWN, !command_present, "shutdown with command")
    `FHW_ASSERT_NOW(a_tx_clean, !empty && !out_kind, end_reason == 3'd0 && !command_present, "reply byte with report fields")

endmodule

bind framed_heartbeat_watchdog_core fhw_checker u_fhw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .tx_byte         (tx_byte),
    .end_reason      (end_reason),
    .command_present (command_present),
    .last_of_run     (last_of_run)
);

// File: dv/wd_scoreboard.sv
// Scoreboard class for the framed heartbeat watchdog: behavioral model and result queue.
class wd_scoreboard;
    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic [2:0] reason;
        logic       present;
        logic       last;
    } wd_res_t;

    wd_res_t     pending[$];
    int          errors;
    logic [15:0] timeout;
    logic [1:0]  phase;
    logic [15:0] flen;
    logic [15:0] seen;
    logic [7:0]  op;
    logic [7:0]  body[31];
    logic [7:0]  cmd[31];
    int          cmd_len;
    logic [16:0] idle;
    bit          halted;
    wd_res_t     burst[$];

    function new();
        errors = 0;
        timeout = 16'd60;
        phase = 0;
        flen = 0;
        seen = 0;
        op = 0;
        cmd_len = 0;
        idle = 0;
        halted = 0;
        for (int i = 0; i < 31; i++)
        begin
            body[i] = 0;
            cmd[i] = 0;
        end
    endfunction

    function void set_timeout(logic [15:0] v);
        timeout = v;
    endfunction

    function void put(logic kind, logic [7:0] tx, logic [2:0] reason, logic present);
        wd_res_t r;
        r.kind = kind;
        r.tx = tx;
        r.reason = reason;
        r.present = present;
        r.last = 0;
        burst.push_back(r);
    endfunction

    function void stop(logic [2:0] reason);
        halted = 1;
        put(fhw_pkg::OUT_REPORT, 8'h00, reason,
            (reason != fhw_pkg::REASON_SHUTDOWN) && (cmd_len != 0));
    endfunction

    function void ack();
        put(fhw_pkg::OUT_TX, 8'h00, 0, 0);
        put(fhw_pkg::OUT_TX, 8'h01, 0, 0);
        put(fhw_pkg::OUT_TX, 8'h01, 0, 0);
    endfunction

    function void run_frame();
        int n;
        logic [15:0] l1;
        n = flen - 1;
        case (op)
            fhw_pkg::OP_HEARTBEAT: idle = 0;
            fhw_pkg::OP_SHUTDOWN: stop(fhw_pkg::REASON_SHUTDOWN);
            fhw_pkg::OP_SET:
            begin
                if (n > 31)
                    n = 31;
                cmd_len = n;
                for (int i = 0; i < n; i++)
                begin
                    cmd[i] = body[i];
                    if (body[i] == 0 && cmd_len == n)
                        cmd_len = i;
                end
                ack();
            end
            fhw_pkg::OP_CLEAR:
            begin
                cmd_len = 0;
                ack();
            end
            fhw_pkg::OP_GET:
            begin
                l1 = cmd_len + 1;
                put(fhw_pkg::OUT_TX, l1[15:8], 0, 0);
                put(fhw_pkg::OUT_TX, l1[7:0], 0, 0);
                put(fhw_pkg::OUT_TX, fhw_pkg::OP_GET_REPLY, 0, 0);
                for (int i = 0; i < cmd_len; i++)
                    put(fhw_pkg::OUT_TX, cmd[i], 0, 0);
            end
            fhw_pkg::OP_CRASHING: stop(fhw_pkg::REASON_CRASHING);
            default: ;
        endcase
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] b);
        bit done;
        done = 0;
        burst.delete();
        if (halted)
            return;
        case (kind)
            fhw_pkg::KIND_BYTE:
            begin
                case (phase)
                    2'd0:
                    begin
                        flen = {b, 8'h00};
                        phase = 1;
                    end
                    2'd1:
                    begin
                        flen = flen | b;
                        seen = 0;
                        phase = (flen == 0) ? 2'd0 : 2'd2;
                    end
                    2'd2:
                    begin
                        op = b;
                        seen = 1;
                        if (seen >= flen)
                            done = 1;
                        else
                            phase = 3;
                    end
                    default:
                    begin
                        if (seen >= 1 && seen - 1 < 31)
                            body[seen - 1] = b;
                        seen = seen + 1;
                        if (seen >= flen)
                            done = 1;
                    end
                endcase
                if (done)
                begin
                    phase = 0;
                    if (flen <= 32)
                        run_frame();
                end
            end
            fhw_pkg::KIND_TICK:
            begin
                if (idle != 17'h1FFFF)
                    idle++;
                if (idle > timeout)
                    stop(fhw_pkg::REASON_TIMEOUT);
            end
            fhw_pkg::KIND_CLOSED: stop(fhw_pkg::REASON_CLOSED);
            default: stop(fhw_pkg::REASON_ERROR);
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1;
        foreach (burst[i])
            pending.push_back(burst[i]);
    endfunction

    function void mismatch(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    function void check_result(wd_res_t got);
        wd_res_t w;
        if (pending.size() == 0)
        begin
            mismatch($sformatf("unexpected result %h", got));
            return;
        end
        w = pending.pop_front();
        if (got.kind !== w.kind)
            mismatch($sformatf("out_kind %0d want %0d", got.kind, w.kind));
        if (got.tx !== w.tx)
            mismatch($sformatf("tx_byte %h want %h", got.tx, w.tx));
        if (got.reason !== w.reason)
            mismatch($sformatf("end_reason %0d want %0d", got.reason, w.reason));
        if (got.present !== w.present)
            mismatch($sformatf("command_present %0d want %0d", got.present, w.present));
        if (got.last !== w.last)
            mismatch($sformatf("last_of_run %0d want %0d", got.last, w.last));
    endfunction
endclass

// File: dv/tb_top.sv
// Top-level testbench for the framed heartbeat watchdog core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fhw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  item_kind;
    logic [7:0]  rx_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        empty;
    logic        pop;
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic [2:0]  end_reason;
    logic        command_present;
    logic        last_of_run;

    wd_scoreboard sb;
    int  cycles;
    bit  calm;
    bit  hold_rx;
    bit  sent_done;

    framed_heartbeat_watchdog_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .item_kind(item_kind), .rx_byte(rx_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .empty(empty), .pop(pop), .out_kind(out_kind), .tx_byte(tx_byte),
        .end_reason(end_reason), .command_present(command_present),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: sample before driving pop for the next edge
    initial
    begin
        pop = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result({out_kind, tx_byte, end_reason, command_present, last_of_run});
            pop <= !hold_rx && (calm || $urandom_range(99) >= 12);
        end
    end

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 12)
        begin
            push <= 0;
            @(posedge clk);
        end
    endtask

    // push stays high after an accepted item; the next send, idle_gap or drain drives it
    task automatic send(logic [1:0] k, logic [7:0] b);
        idle_gap();
        push <= 1;
        item_kind <= k;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(k, b);
    endtask

    task automatic send_byte(logic [7:0] b);
        send(KIND_BYTE, b);
    endtask

    task automatic frame(logic [7:0] op, int body_len, bit nz);
        logic [15:0] l;
        l = 16'(body_len + 1);
        send_byte(l[15:8]);
        send_byte(l[7:0]);
        send_byte(op);
        for (int i = 0; i < body_len; i++)
            send_byte(nz ? 8'($urandom_range(255, 1)) : 8'($urandom));
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        sb.set_timeout(v);
    endtask

    // reset between phases is not allowed, so termination ends a run; avoid it in random
    task automatic random_session(int n);
        int c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(99);
            if (c < 20)
                send(KIND_TICK, 8'($urandom));
            else if (c < 35)
                frame(OP_HEARTBEAT, $urandom_range(3), 0);
            else if (c < 55)
                frame(OP_SET, ($urandom_range(9) == 0) ? 31 : $urandom_range(6),
                      $urandom_range(3) != 0);
            else if (c < 70)
                frame(OP_GET, $urandom_range(2), 0);
            else if (c < 75)
                frame(OP_CLEAR, 0, 0);
            else if (c < 82)
            begin
                logic [7:0] o;
                o = 8'($urandom);
                if (o == OP_SHUTDOWN || o == OP_CRASHING)
                    o = 8'hFF;
                frame(o, $urandom_range(4), 0);
            end
            else if (c < 86)
                frame(OP_SET, 32 + $urandom_range(8), 0);
            else if (c < 90)
            begin
                send_byte(0);
                send_byte(0);
            end
            else
                send_byte(8'($urandom));
            if (i % 10 == 9)
                frame(OP_HEARTBEAT, 0, 0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        push = 0;
        item_kind = 0;
        rx_byte = 0;
        cfg_valid = 0;
        cfg_data = 0;
        calm = 0;
        hold_rx = 0;
        sent_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, set, get, clear and heartbeat ops, zero-length, oversize, zero in set body
        write_timeout(16'd11);
        send_byte(0);
        send_byte(0);
        frame(OP_GET, 0, 0);
        frame(OP_SET, 3, 1);
        send_byte(0);
        send_byte(3);
        send_byte(OP_SET);
        send_byte(8'h41);
        send_byte(8'h00);
        frame(OP_GET, 0, 0);
        frame(OP_SET, 31, 1);
        frame(OP_GET, 0, 0);
        frame(8'hFF, 1, 0);
        frame(8'h00, 0, 0);
        frame(OP_GET_REPLY, 0, 0);
        frame(OP_SET, 33, 0);
        frame(OP_CLEAR, 0, 0);
        repeat (11) send(KIND_TICK, 8'hFF);
        frame(OP_HEARTBEAT, 0, 0);
        drain();

        // long receiver stall while get-command frames are offered at the input
        write_timeout(16'd65535);
        frame(OP_SET, 20, 1);
        drain();
        fork
            begin
                hold_rx = 1;
                repeat (300) @(posedge clk);
                hold_rx = 0;
            end
            repeat (4) frame(OP_GET, 0, 0);
        join
        drain();

        write_timeout(16'd200);
        random_session(8);
        calm = 1;
        random_session(8);
        calm = 0;
        drain();
        write_timeout(16'd30);
        random_session(8);
        drain();

        // terminate: report then halt
        frame(OP_SET, 4, 1);
        for (int i = 0; i < 31; i++)
            send(KIND_TICK, 0);
        send(KIND_ERROR, 8'hFF);
        send(KIND_CLOSED, 0);
        frame(OP_SHUTDOWN, 0, 0);
        send_byte(8'hAA);
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
